// File: rtl/core/ces_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ces_pkg: shared types and constants of the cosine similarity engine
// Holds the job record passed from the accumulating front to the divider
// back, the sequencer states, result codes and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package ces_pkg;

  // Accumulator widths (integer sums: signed Q40.0 dot, unsigned UQ40.0 squares).
  localparam int DOT_W  = 41;
  localparam int SUM_W  = 40;
  localparam int HALF_W = SUM_W / 2;
  localparam int RAD_W  = 2 * SUM_W;
  localparam int ROOT_W = SUM_W;
  // Dividend is |dot| scaled by 2^14.
  localparam int FRAC_W = 14;
  localparam int NUM_W  = DOT_W + FRAC_W;
  localparam int CNT_W  = 6;

  // Saturation limits of the dot product sum, at one guard bit.
  localparam logic signed [DOT_W:0] DOT_MAX = 42'sh0FF_FFFF_FFFF;
  localparam logic signed [DOT_W:0] DOT_MIN = -DOT_MAX - 42'sd1;

  // Result values in Q2.14.
  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam logic [15:0] ERR_Q14 = 16'h8000;

  // Job queue depth between front and back.
  localparam int JOB_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_TYPE  = 2'd1,
    ST_ODD_COUNT = 2'd2,
    ST_ZERO_NORM = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SQRT,
    BK_DIV,
    BK_DONE
  } back_state_t;

  // One finished vector pair, ready for the normalization step.
  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [SUM_W-1:0]        sxx;
    logic [SUM_W-1:0]        syy;
    logic                    odd;
    logic                    bad;
  } job_t;

endpackage
`default_nettype wire

// File: rtl/core/ces_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ces_front: element pair intake and accumulation
// Registers the three products of each accepted pair, adds them into
// saturating sums and hands a finished job to the queue on the last item.
// ----------------------------------------------------------------------------
module ces_front #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [15:0]   x_value,
  input  logic signed [15:0]   y_value,
  input  logic                 not_numeric,
  input  logic                 unmatched,
  input  logic                 last,
  output logic                 job_push,
  output ces_pkg::job_t        job,
  input  logic                 job_full
);
  import ces_pkg::*;

  localparam int PW = 2 * VALUE_WIDTH;

  logic signed [VALUE_WIDTH-1:0] x_in;
  logic signed [VALUE_WIDTH-1:0] y_in;
  logic signed [PW-1:0]          xy_prod;
  logic signed [PW-1:0]          xx_prod;
  logic signed [PW-1:0]          yy_prod;

  logic                    s1_valid;
  logic signed [PW-1:0]    s1_xy;
  logic [PW-1:0]           s1_xx;
  logic [PW-1:0]           s1_yy;
  logic                    s1_bad;
  logic                    s1_odd;
  logic                    s1_last;

  logic signed [DOT_W-1:0] dot_sum;
  logic [SUM_W-1:0]        x_square_sum;
  logic [SUM_W-1:0]        y_square_sum;
  logic                    type_error_seen;

  logic signed [DOT_W:0]   dot_wide;
  logic signed [DOT_W-1:0] dot_next;
  logic [SUM_W:0]          xsq_wide;
  logic [SUM_W:0]          ysq_wide;
  logic [SUM_W-1:0]        xsq_next;
  logic [SUM_W-1:0]        ysq_next;
  logic                    step;

  // Only the low VALUE_WIDTH bits of each element take part.
  assign x_in    = x_value[VALUE_WIDTH-1:0];
  assign y_in    = y_value[VALUE_WIDTH-1:0];
  assign xy_prod = x_in * y_in;
  assign xx_prod = x_in * x_in;
  assign yy_prod = y_in * y_in;

  // A last item waits in the product stage while the queue is full.
  assign full = s1_valid & s1_last & job_full;
  assign step = s1_valid & ~full;

  // Product stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!full) begin
      s1_valid <= push;
    end
  end

  // Product stage payload; a non-numeric pair contributes nothing.
  always_ff @(posedge clk) begin
    if (!full && push) begin
      s1_xy   <= not_numeric ? '0 : xy_prod;
      s1_xx   <= not_numeric ? '0 : PW'(xx_prod);
      s1_yy   <= not_numeric ? '0 : PW'(yy_prod);
      s1_bad  <= not_numeric;
      s1_odd  <= unmatched;
      s1_last <= last;
    end
  end

  // Saturating sums.
  always_comb begin
    dot_wide = (DOT_W + 1)'(dot_sum) + (DOT_W + 1)'(s1_xy);
    if (dot_wide > DOT_MAX) begin
      dot_next = DOT_MAX[DOT_W-1:0];
    end else if (dot_wide < DOT_MIN) begin
      dot_next = DOT_MIN[DOT_W-1:0];
    end else begin
      dot_next = dot_wide[DOT_W-1:0];
    end
    xsq_wide = {1'b0, x_square_sum} + (SUM_W + 1)'(s1_xx);
    ysq_wide = {1'b0, y_square_sum} + (SUM_W + 1)'(s1_yy);
    xsq_next = xsq_wide[SUM_W] ? '1 : xsq_wide[SUM_W-1:0];
    ysq_next = ysq_wide[SUM_W] ? '1 : ysq_wide[SUM_W-1:0];
  end

  // Accumulators clear once a vector pair has been handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum         <= '0;
      x_square_sum    <= '0;
      y_square_sum    <= '0;
      type_error_seen <= 1'b0;
    end else if (step) begin
      if (s1_last) begin
        dot_sum         <= '0;
        x_square_sum    <= '0;
        y_square_sum    <= '0;
        type_error_seen <= 1'b0;
      end else begin
        dot_sum         <= dot_next;
        x_square_sum    <= xsq_next;
        y_square_sum    <= ysq_next;
        type_error_seen <= type_error_seen | s1_bad;
      end
    end
  end

  // Finished job, including the last pair itself.
  assign job_push = step & s1_last;
  always_comb begin
    job.dot = dot_next;
    job.sxx = xsq_next;
    job.syy = ysq_next;
    job.odd = s1_odd;
    job.bad = type_error_seen | s1_bad;
  end

endmodule
`default_nettype wire

// File: rtl/core/ces_job_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ces_job_queue: short queue of finished jobs
// Decouples the accumulating front from the square root and divide back.
// ----------------------------------------------------------------------------
module ces_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ces_pkg::job_t wr_job,
  output logic          q_full,
  input  logic          rd_en,
  output ces_pkg::job_t rd_job,
  output logic          q_empty
);
  import ces_pkg::*;

  localparam int PTR_W = $clog2(JOB_DEPTH);

  job_t             slots [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign q_full  = (count == (PTR_W + 1)'(JOB_DEPTH));
  assign q_empty = (count == '0);
  assign rd_job  = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ces_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ces_back: normalization sequencer
// Classifies a job, forms sumxx*sumyy from four partial products, takes its
// integer square root one bit a cycle and divides |dot|*2^14 by it one bit
// a cycle. The result waits in an output register.
// ----------------------------------------------------------------------------
module ces_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  input  ces_pkg::job_t job_head,
  input  logic          job_empty,
  output logic          job_pop,
  output logic          empty,
  input  logic          pop,
  output logic [15:0]   similarity,
  output logic [1:0]    status
);
  import ces_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic        res_load;

  logic [15:0]         threshold;
  logic [CNT_W-1:0]    cnt;
  status_t             pend_status;
  logic                neg;
  logic [SUM_W-1:0]    op_x;
  logic [SUM_W-1:0]    op_y;
  logic [2*HALF_W-1:0] mul_prod;
  logic [1:0]          mul_code;
  logic [RAD_W-1:0]    rad;
  logic [ROOT_W:0]     rem_s;
  logic [ROOT_W-1:0]   root;
  logic [NUM_W-1:0]    num;
  logic [ROOT_W-1:0]   rem_d;
  logic [NUM_W-1:0]    quo;

  logic                res_valid;
  logic [15:0]         res_sim;
  status_t             res_status;

  logic                zero_norm;
  logic [DOT_W-1:0]    mag;
  logic [HALF_W-1:0]   half_x;
  logic [HALF_W-1:0]   half_y;
  logic [RAD_W-1:0]    add_term;
  logic [ROOT_W+2:0]   rem_try;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W:0]     div_try;
  logic [15:0]         q_clamp;
  logic [15:0]         sim_ok;
  logic [15:0]         sim_out;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  // Job classification at the queue head.
  assign zero_norm = (job_head.sxx <= SUM_W'(threshold)) ||
                     (job_head.syy <= SUM_W'(threshold));
  assign mag = job_head.dot[DOT_W-1] ? DOT_W'(-job_head.dot) : DOT_W'(job_head.dot);

  // Next state and handshake controls.
  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    res_load   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          if (job_head.odd || job_head.bad || zero_norm) begin
            state_next = BK_DONE;
          end else begin
            state_next = BK_MUL;
          end
        end
      end
      BK_MUL: begin
        if (cnt == CNT_W'(4)) begin
          state_next = BK_SQRT;
        end
      end
      BK_SQRT: begin
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt == CNT_W'(NUM_W - 1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!res_valid || pop) begin
          res_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // State register and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
    end
  end

  // Partial product operand select: low/low, low/high, high/low, high/high.
  always_comb begin
    half_x = cnt[1] ? op_x[SUM_W-1:HALF_W] : op_x[HALF_W-1:0];
    half_y = cnt[0] ? op_y[SUM_W-1:HALF_W] : op_y[HALF_W-1:0];
    case (mul_code)
      2'd0:    add_term = RAD_W'(mul_prod);
      2'd1:    add_term = RAD_W'(mul_prod) << HALF_W;
      2'd2:    add_term = RAD_W'(mul_prod) << HALF_W;
      default: add_term = RAD_W'(mul_prod) << (2 * HALF_W);
    endcase
  end

  // Square root and division trial subtractions.
  assign rem_try = {rem_s, rad[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign div_try = {rem_d, num[NUM_W-1]};

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (job_pop) begin
          if (job_head.odd) begin
            pend_status <= ST_ODD_COUNT;
          end else if (job_head.bad) begin
            pend_status <= ST_BAD_TYPE;
          end else if (zero_norm) begin
            pend_status <= ST_ZERO_NORM;
          end else begin
            pend_status <= ST_OK;
          end
          neg   <= job_head.dot[DOT_W-1];
          op_x  <= job_head.sxx;
          op_y  <= job_head.syy;
          num   <= {mag, FRAC_W'(0)};
          rad   <= '0;
          rem_s <= '0;
          root  <= '0;
          rem_d <= '0;
          quo   <= '0;
        end
      end
      BK_MUL: begin
        if (cnt[CNT_W-1:2] == '0) begin
          mul_prod <= half_x * half_y;
          mul_code <= cnt[1:0];
        end
        if (cnt != '0) begin
          rad <= rad + add_term;
        end
      end
      BK_SQRT: begin
        rad <= rad << 2;
        if (rem_try >= trial) begin
          rem_s <= (ROOT_W + 1)'(rem_try - trial);
          root  <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem_s <= rem_try[ROOT_W:0];
          root  <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      BK_DIV: begin
        num <= num << 1;
        if (div_try >= {1'b0, root}) begin
          rem_d <= ROOT_W'(div_try - {1'b0, root});
          quo   <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem_d <= div_try[ROOT_W-1:0];
          quo   <= {quo[NUM_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  // Clamp, sign and error encoding of the result.
  always_comb begin
    if (root == '0 || quo > NUM_W'(ONE_Q14)) begin
      q_clamp = ONE_Q14;
    end else begin
      q_clamp = quo[15:0];
    end
    sim_ok = neg ? 16'(-q_clamp) : q_clamp;
    case (pend_status)
      ST_OK:       sim_out = sim_ok;
      ST_BAD_TYPE: sim_out = '0;
      default:     sim_out = ERR_Q14;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_sim    <= sim_out;
      res_status <= pend_status;
    end
  end

  assign empty      = ~res_valid;
  assign similarity = res_sim;
  assign status     = res_status;

endmodule
`default_nettype wire

// File: rtl/core/cosine_similarity_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_similarity_engine_core: streaming cosine similarity of two vectors
// Accepts one element pair per cycle while full is low; emits one Q2.14 result per vector pair.
// ----------------------------------------------------------------------------
// Throughput: one element pair per cycle while the job queue has room.
// After the last pair, a normal vector goes through 5 multiply, 40 square
// root and 55 divide steps; error cases go straight to the result register.
// The bit-serial square root and divide take one job at a time, while the
// front keeps accepting pairs; two finished vectors can wait in the job queue.
// Synchronous reset clears the sums, queue, result valid flag and threshold.
module cosine_similarity_engine_core #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] x_value,
  input  logic signed [15:0] y_value,
  input  logic               not_numeric,
  input  logic               unmatched,
  input  logic               last,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] similarity,
  output logic [1:0]         status
);
  import ces_pkg::*;

  job_t job_in;
  job_t job_out;
  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;
  logic [15:0] sim_bits;

  // Intake and accumulation.
  ces_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .x_value    (x_value),
    .y_value    (y_value),
    .not_numeric(not_numeric),
    .unmatched  (unmatched),
    .last       (last),
    .job_push   (job_push),
    .job        (job_in),
    .job_full   (job_full)
  );

  // Finished jobs between the two sides.
  ces_job_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (job_in),
    .q_full (job_full),
    .rd_en  (job_pop),
    .rd_job (job_out),
    .q_empty(job_empty)
  );

  // Square root, divide and result register.
  ces_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .job_head  (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .similarity(sim_bits),
    .status    (status)
  );

  assign similarity = sim_bits;

endmodule
`default_nettype wire

// File: dv/cosine_similarity_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cosine_similarity_engine_core_tb: self-checking bench for the cosine core
// Streams element pairs through the push/full side and pops results through
// the empty/pop side. A bit-accurate predictor of the accumulate, square root
// and divide path computes each expected cosine and status. A directed table
// covers the error codes and extremes, followed by random vectors over three
// idle profiles and several zero-norm thresholds, including one overlong
// vector that saturates every sum.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_core_tb;
  import ces_pkg::*;

  localparam int     MAX_PAIRS     = 256;
  localparam int     SETTLE_CYCLES = 150;
  localparam int     CYCLE_LIMIT   = 1000000;
  localparam int     LONG_PAIRS    = 1060;
  localparam longint DOT_HI        = (longint'(1) << 40) - 1;
  localparam longint DOT_LO        = -DOT_HI - 1;
  localparam longint unsigned SQ_HI = (longint'(1) << 40) - 1;
  localparam logic [15:0] MINUS_ONE_Q14 = 16'hC000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 nn;
    bit                 unm;
    bit                 lst;
  } pair_t;

  typedef struct packed {
    logic [15:0] sim;
    status_t     st;
  } cos_result_t;

  typedef struct {
    pair_t       p;
    bit          given;
    cos_result_t res;
  } row_t;

  // Block ports.
  logic               clk;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] x_value = '0;
  logic signed [15:0] y_value = '0;
  logic               not_numeric = 1'b0;
  logic               unmatched = 1'b0;
  logic               last = 1'b0;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_data = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] similarity;
  logic [1:0]         status;

  // Predictor state: running sums of the current vector and the threshold.
  longint          acc_dot;
  longint unsigned acc_xx;
  longint unsigned acc_yy;
  bit              acc_bad;
  logic [15:0]     norm_floor;

  cos_result_t cos_results_due[$];
  cos_result_t due_cos;
  row_t        directed_rows[$];
  int          mismatch_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          cycle_count = 0;

  cosine_similarity_engine_core u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .x_value     (x_value),
    .y_value     (y_value),
    .not_numeric (not_numeric),
    .unmatched   (unmatched),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .empty       (empty),
    .pop         (pop),
    .similarity  (similarity),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit in case the block stops producing results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL cosine_similarity_engine_core");
      $finish;
    end
  end

  // floor(sqrt(a*b)), one root bit per step from the top.
  function automatic logic [40:0] root_of_product(input logic [39:0] a,
                                                  input logic [39:0] b);
    logic [79:0] prod;
    logic [40:0] root;
    logic [40:0] trial;
    logic [81:0] trial_sq;
    int          k;
    prod = a * b;
    root = '0;
    for (k = 40; k >= 0; k--) begin
      trial    = root | (41'd1 << k);
      trial_sq = trial * trial;
      if (trial_sq <= {2'b00, prod}) root = trial;
    end
    return root;
  endfunction

  // Fold one item into the sums; on the last item, produce the cosine.
  function automatic bit cosine_step(input pair_t p, output cos_result_t r);
    longint          xv;
    longint          yv;
    longint          d;
    longint unsigned xx;
    longint unsigned yy;
    longint unsigned mag;
    longint unsigned q;
    logic [40:0]     den;
    bit              neg;
    r = '{sim: '0, st: ST_OK};
    if (p.nn) begin
      acc_bad = 1'b1;
    end else begin
      xv = p.x;
      yv = p.y;
      xx = longint'(xv * xv);
      yy = longint'(yv * yv);
      d  = acc_dot + xv * yv;
      acc_dot = (d > DOT_HI) ? DOT_HI : ((d < DOT_LO) ? DOT_LO : d);
      acc_xx  = (SQ_HI - acc_xx < xx) ? SQ_HI : acc_xx + xx;
      acc_yy  = (SQ_HI - acc_yy < yy) ? SQ_HI : acc_yy + yy;
    end
    if (!p.lst) return 1'b0;

    // Odd count outranks bad type, which outranks a zero norm.
    if (p.unm) begin
      r = '{sim: ERR_Q14, st: ST_ODD_COUNT};
    end else if (acc_bad) begin
      r = '{sim: 16'd0, st: ST_BAD_TYPE};
    end else if (acc_xx <= norm_floor || acc_yy <= norm_floor) begin
      r = '{sim: ERR_Q14, st: ST_ZERO_NORM};
    end else begin
      den = root_of_product(acc_xx[39:0], acc_yy[39:0]);
      neg = acc_dot < 0;
      mag = neg ? longint'(-acc_dot) : longint'(acc_dot);
      q   = (den != 0) ? (mag * 16384) / den : 16384;
      if (q > 16384) q = 16384;
      r.sim = neg ? 16'(-q[15:0]) : q[15:0];
      r.st  = ST_OK;
    end
    acc_dot = 0;
    acc_xx  = 0;
    acc_yy  = 0;
    acc_bad = 1'b0;
    return 1'b1;
  endfunction

  // Offer one item until it is taken, then queue what it should produce.
  task automatic send_pair(input pair_t p, input bit given, input cos_result_t fixed);
    cos_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    x_value     <= p.x;
    y_value     <= p.y;
    not_numeric <= p.nn;
    unmatched   <= p.unm;
    last        <= p.lst;
    do @(posedge clk); while (full);
    if (cosine_step(p, r)) cos_results_due.push_back(given ? fixed : r);
  endtask

  // Stop sending and wait for every queued result to come out.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (cos_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_norm_floor(input logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    norm_floor = v;
  endtask

  task automatic add_row(input int x, input int y, input bit nn, input bit unm,
                         input bit lst, input bit given, input logic [15:0] sim,
                         input status_t st);
    row_t row;
    row.p     = '{x: 16'(x), y: 16'(y), nn: nn, unm: unm, lst: lst};
    row.given = given;
    row.res   = '{sim: sim, st: st};
    directed_rows.push_back(row);
  endtask

  // One random vector; the value style sets how often the edge cases appear.
  task automatic send_random_vector(output int sent);
    pair_t       p;
    cos_result_t none;
    int          len;
    int          style;
    int          roll;
    int          v;
    int          i;
    bit          flip;
    none = '{sim: '0, st: ST_OK};
    roll = $urandom_range(99);
    if (roll < 75) len = $urandom_range(1, 4);
    else if (roll < 97) len = $urandom_range(5, 24);
    else len = $urandom_range(25, MAX_PAIRS);
    style = $urandom_range(5);
    flip  = 1'($urandom_range(1));
    for (i = 0; i < len; i++) begin
      case (style)
        0: begin
          p.x = 16'($urandom);
          p.y = 16'($urandom);
        end
        1: begin
          p.x = 16'(int'($urandom_range(16)) - 8);
          p.y = 16'(int'($urandom_range(16)) - 8);
        end
        2: begin
          p.x = 16'(int'($urandom_range(4095)) - 2048);
          p.y = 16'(int'($urandom_range(4095)) - 2048);
        end
        3: begin
          // Nearly parallel or antiparallel, to land on the clamp.
          p.x = 16'($urandom);
          v   = flip ? -int'(p.x) : int'(p.x);
          if ($urandom_range(3) == 0) v = v + int'($urandom_range(2)) - 1;
          p.y = 16'(v);
        end
        4: begin
          p.x = flip ? 16'sd0 : 16'($urandom);
          p.y = flip ? 16'($urandom) : 16'sd0;
        end
        default: begin
          case ($urandom_range(3))
            0: p.x = -16'sd32768;
            1: p.x = 16'sd32767;
            2: p.x = 16'sd0;
            default: p.x = -16'sd1;
          endcase
          p.y = ($urandom_range(1) == 1) ? -16'sd32768 : 16'($urandom);
        end
      endcase
      p.nn  = ($urandom_range(39) == 0);
      p.lst = (i == len - 1);
      p.unm = p.lst ? ($urandom_range(9) == 0) : 1'($urandom_range(1));
      send_pair(p, 1'b0, none);
    end
    sent = len;
  endtask

  // Result side: check every popped item against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (cos_results_due.size() == 0) begin
          $display("%0t: unexpected result: similarity %0d status %0d", $time,
                   similarity, status);
          mismatch_count++;
        end else begin
          due_cos = cos_results_due.pop_front();
          if (similarity !== due_cos.sim) begin
            $display("%0t: similarity mismatch: expected %0d, actual %0d", $time,
                     $signed(due_cos.sim), similarity);
            mismatch_count++;
          end
          if (status !== due_cos.st) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     due_cos.st, status);
            mismatch_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Stimulus: directed table, then three phases of random vectors.
  initial begin
    pair_t       p;
    cos_result_t none;
    int          items;
    int          target;
    int          n;
    int          ph;
    int          i;
    bit          paused;
    bit          same_sign;
    none     = '{sim: '0, st: ST_OK};
    acc_dot  = 0;
    acc_xx   = 0;
    acc_yy   = 0;
    acc_bad  = 1'b0;
    norm_floor = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_norm_floor(16'd0);

    // Zero vectors, the smallest norm above a zero threshold.
    add_row(0, 0, 0, 0, 1, 1, ERR_Q14, ST_ZERO_NORM);
    add_row(1, 1, 0, 0, 1, 1, ONE_Q14, ST_OK);
    add_row(0, 5, 0, 0, 1, 1, ERR_Q14, ST_ZERO_NORM);
    // Odd count, bad type (early and on the last item), and their priority.
    add_row(3, 7, 0, 1, 1, 1, ERR_Q14, ST_ODD_COUNT);
    add_row(5, 5, 1, 0, 0, 0, '0, ST_OK);
    add_row(1, 1, 0, 0, 1, 1, 16'd0, ST_BAD_TYPE);
    add_row(1, 1, 0, 0, 0, 0, '0, ST_OK);
    add_row(2, 2, 1, 0, 1, 1, 16'd0, ST_BAD_TYPE);
    add_row(4, 4, 1, 1, 1, 1, ERR_Q14, ST_ODD_COUNT);
    // Unmatched on an item that is not last is ignored.
    add_row(256, 256, 0, 1, 0, 0, '0, ST_OK);
    add_row(256, 256, 0, 0, 1, 1, ONE_Q14, ST_OK);
    // Full-scale elements give exact roots and land on plus or minus one.
    add_row(32767, -32768, 0, 0, 1, 1, MINUS_ONE_Q14, ST_OK);
    add_row(-32768, -32768, 0, 0, 1, 1, ONE_Q14, ST_OK);
    add_row(-32768, 32767, 0, 0, 1, 1, MINUS_ONE_Q14, ST_OK);
    // Mixed vectors left to the predictor.
    add_row(100, 300, 0, 0, 0, 0, '0, ST_OK);
    add_row(-50, 70, 0, 0, 0, 0, '0, ST_OK);
    add_row(7, -9, 0, 0, 1, 0, '0, ST_OK);
    add_row(32767, 1, 0, 0, 0, 0, '0, ST_OK);
    add_row(1, 32767, 0, 0, 0, 0, '0, ST_OK);
    add_row(-1, -1, 0, 0, 1, 0, '0, ST_OK);
    add_row(-1, 1, 0, 0, 0, 0, '0, ST_OK);
    add_row(2, -3, 0, 0, 0, 0, '0, ST_OK);
    add_row(-4, 5, 0, 0, 0, 0, '0, ST_OK);
    add_row(6, -7, 0, 0, 1, 0, '0, ST_OK);
    foreach (directed_rows[i]) send_pair(directed_rows[i].p, directed_rows[i].given,
                                         directed_rows[i].res);

    for (ph = 0; ph < 3; ph++) begin
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (ph)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 67;
          target      = 350;
          set_norm_floor(16'($urandom_range(1, 4095)));
        end
        1: begin
          tx_idle_pct = 67;
          rx_idle_pct = 16;
          target      = 350;
          set_norm_floor(16'hFFFF);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          target      = 120;
          set_norm_floor(16'($urandom_range(65535)));
        end
      endcase

      // Overlong vector of full-scale elements: every sum saturates.
      if (ph == 2) begin
        same_sign = 1'($urandom_range(1));
        for (i = 0; i < LONG_PAIRS; i++) begin
          p.x   = ($urandom_range(1) == 1) ? -16'sd32768 : 16'sd32767;
          p.y   = ((p.x < 0) == same_sign) ? -16'sd32768 : 16'sd32767;
          p.nn  = 1'b0;
          p.unm = 1'b0;
          p.lst = (i == LONG_PAIRS - 1);
          send_pair(p, 1'b0, none);
        end
      end

      items  = 0;
      paused = 1'b0;
      while (items < target) begin
        // Midway through the slow-sender phase, let the block run dry.
        if (ph == 1 && !paused && items >= target / 2) begin
          wait_for_drain();
          paused = 1'b1;
        end
        send_random_vector(n);
        items += n;
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS cosine_similarity_engine_core");
    end else begin
      $display("FAIL cosine_similarity_engine_core");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ces_pkg.sv
rtl/core/ces_front.sv
rtl/core/ces_job_queue.sv
rtl/core/ces_back.sv
rtl/core/cosine_similarity_engine_core.sv
dv/cosine_similarity_engine_core_tb.sv
